/* design/tfh_pkg.sv */
package tfh_pkg;

  // Field widths: time, tag port and seconds fixed by the port list, retention in ns
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned TAG_PORT_W = 16;
  localparam int unsigned SECS_W     = 12;
  localparam int unsigned KEEP_W     = 42;

  // Retention window limits and scale
  localparam logic [SECS_W-1:0] SECONDS_MIN   = 12'd3;
  localparam logic [SECS_W-1:0] SECONDS_MAX   = 12'd3603;
  localparam logic [29:0]       NS_PER_SECOND = 30'd1_000_000_000;

  // Command codes
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_PLAY  = 2'd1;
  localparam logic [1:0] CMD_LOOK  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_STORED  = 2'd1;
  localparam logic [1:0] ST_RESET   = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  // Ring access request, one access per cycle
  typedef struct packed {
    logic rd;
    logic wr;
  } ring_req_t;

endpackage

/* design/tfh_ring.sv */
module tfh_ring #(
  parameter int unsigned HISTORY_DEPTH = 8192,
  parameter int unsigned TB            = 16
) (
  input  logic                              clk,
  input  tfh_pkg::ring_req_t                req,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]  oldest,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]  offset,
  input  logic [tfh_pkg::TIME_W-1:0]        wr_time,
  input  logic [TB-1:0]                     wr_tag,
  output logic [tfh_pkg::TIME_W-1:0]        rd_time,
  output logic [TB-1:0]                     rd_tag
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic [tfh_pkg::TIME_W-1:0] times_mem [HISTORY_DEPTH];
  logic [TB-1:0]              tags_mem  [HISTORY_DEPTH];
  logic [AW:0]                sum;
  logic [AW-1:0]              slot;

  // Map a position counted from the oldest entry onto a ring slot
  assign sum  = (AW+1)'(oldest) + (AW+1)'(offset);
  assign slot = (sum >= (AW+1)'(HISTORY_DEPTH)) ? AW'(sum - (AW+1)'(HISTORY_DEPTH))
                                                : AW'(sum);

  // Write and registered read through one address
  always_ff @(posedge clk) begin
    if (req.wr) begin
      times_mem[slot] <= wr_time;
      tags_mem[slot]  <= wr_tag;
    end
    if (req.rd) begin
      rd_time <= times_mem[slot];
      rd_tag  <= tags_mem[slot];
    end
  end

endmodule

/* design/timestamped_frame_history_core.sv */
// Frame history: a time-ordered ring of (timestamp, frame tag) entries held
// in one single-port memory, driven by a small sequencer around one shared
// 64-bit comparator. One transaction is taken at a time and gives one result.
// A push checks the newest entry, sets and lowers the cutoff, evicts old
// entries (each eviction is a memory read and a compare), enforces the size
// limit and appends; a lookup is a binary search over the held entries;
// playback updates and clears need no memory access. A new transaction is
// taken while the previous result still waits at the output.
// Configuration writes land at once and must come while the block is idle.
// The ring needs no clearing after reset: only held entries are ever read.
module timestamped_frame_history_core #(
  parameter int unsigned HISTORY_DEPTH = 8192,
  parameter int unsigned TAG_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_time_ns,
  input  logic [15:0] in_frame_tag,
  input  logic        in_paused,
  input  logic        in_emitting_hold,
  input  logic        in_emitting_delayed,
  input  logic [63:0] in_emitted_time,
  input  logic [63:0] in_buffer_start_time,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [63:0] out_entry_time,
  output logic [15:0] out_entry_tag,
  output logic        out_suspended,
  output logic [1:0]  out_status
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned TB = (TAG_BITS < tfh_pkg::TAG_PORT_W) ? TAG_BITS
                                                                 : tfh_pkg::TAG_PORT_W;
  localparam int unsigned LW = (CW > 13) ? CW : 13;
  localparam int unsigned TW = tfh_pkg::TIME_W;
  localparam int unsigned KW = tfh_pkg::KEEP_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NEWEST = 4'd1;
  localparam logic [3:0] S_CUT    = 4'd2;
  localparam logic [3:0] S_PROT   = 4'd3;
  localparam logic [3:0] S_EV_RD  = 4'd4;
  localparam logic [3:0] S_EV_CMP = 4'd5;
  localparam logic [3:0] S_LIMIT  = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_LK_RD  = 4'd8;
  localparam logic [3:0] S_LK_CMP = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0]                       state_r, state_nxt;
  logic [tfh_pkg::SECS_W-1:0]       secs_r, secs_nxt;
  logic [AW-1:0]                    oldest_r, oldest_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [TW-1:0]                    prot_r, prot_nxt;
  logic [TW-1:0]                    hold_r, hold_nxt;
  logic                             susp_r, susp_nxt;
  logic                             out_valid_r, out_valid_nxt;

  logic [TW-1:0]                    t_r, t_nxt;
  logic [TB-1:0]                    tag_r, tag_nxt;
  logic [KW-1:0]                    keep_r, keep_nxt;
  logic [TW-1:0]                    cutoff_r, cutoff_nxt;
  logic [CW-1:0]                    lo_r, lo_nxt;
  logic [CW-1:0]                    hi_r, hi_nxt;
  logic [CW-1:0]                    mid_r, mid_nxt;
  logic                             found_r, found_nxt;
  logic [TW-1:0]                    etime_r, etime_nxt;
  logic [TB-1:0]                    etag_r, etag_nxt;
  logic [1:0]                       status_r, status_nxt;

  logic                             out_found_r;
  logic [TW-1:0]                    out_time_r;
  logic [TB-1:0]                    out_tag_r;
  logic                             out_susp_r;
  logic [1:0]                       out_status_r;

  tfh_pkg::ring_req_t               ring_req;
  logic [AW-1:0]                    ring_off;
  logic [TW-1:0]                    rd_time;
  logic [TB-1:0]                    rd_tag;

  logic [TW-1:0]                    cmp_a, cmp_b;
  logic                             cmp_le;
  logic [TW:0]                      cut_diff;
  logic [AW-1:0]                    oldest_inc;
  logic [CW-1:0]                    cnt_m1;
  logic [CW-1:0]                    mid_calc;
  logic [12:0]                      lim_raw;
  logic [LW-1:0]                    limit;
  logic                             accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Ring storage
  tfh_ring #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TB            (TB)
  ) u_ring (
    .clk     (clk),
    .req     (ring_req),
    .oldest  (oldest_r),
    .offset  (ring_off),
    .wr_time (t_r),
    .wr_tag  (tag_r),
    .rd_time (rd_time),
    .rd_tag  (rd_tag)
  );

  // Shared comparator: operands follow the sequencer step
  always_comb begin
    unique case (state_r)
      S_NEWEST: begin cmp_a = t_r;      cmp_b = rd_time; end
      S_PROT:   begin cmp_a = cutoff_r; cmp_b = prot_r;  end
      S_EV_CMP: begin cmp_a = rd_time;  cmp_b = cutoff_r; end
      S_LK_CMP: begin cmp_a = rd_time;  cmp_b = t_r;     end
      default:  begin cmp_a = rd_time;  cmp_b = t_r;     end
    endcase
  end
  assign cmp_le = (cmp_a <= cmp_b);

  // Small helpers
  assign cut_diff   = {1'b0, t_r} - {1'b0, TW'(keep_r)};
  assign oldest_inc = (oldest_r == AW'(HISTORY_DEPTH - 1)) ? '0 : oldest_r + AW'(1);
  assign cnt_m1     = cnt_r - CW'(1);
  assign mid_calc   = lo_r + ((hi_r - lo_r) >> 1);
  assign lim_raw    = {secs_r, 1'b0} + 13'd4;
  assign limit      = (LW'(lim_raw) > LW'(HISTORY_DEPTH)) ? LW'(HISTORY_DEPTH)
                                                          : LW'(lim_raw);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    secs_nxt      = secs_r;
    oldest_nxt    = oldest_r;
    cnt_nxt       = cnt_r;
    prot_nxt      = prot_r;
    hold_nxt      = hold_r;
    susp_nxt      = susp_r;
    t_nxt         = t_r;
    tag_nxt       = tag_r;
    keep_nxt      = keep_r;
    cutoff_nxt    = cutoff_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    found_nxt     = found_r;
    etime_nxt     = etime_r;
    etag_nxt      = etag_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ring_req      = '{rd: 1'b0, wr: 1'b0};
    ring_off      = '0;

    // Clamp a configuration write into the legal window
    if (cfg_wr_en) begin
      if (cfg_wr_data < tfh_pkg::SECONDS_MIN) begin
        secs_nxt = tfh_pkg::SECONDS_MIN;
      end else if (cfg_wr_data > tfh_pkg::SECONDS_MAX) begin
        secs_nxt = tfh_pkg::SECONDS_MAX;
      end else begin
        secs_nxt = cfg_wr_data;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          t_nxt      = in_time_ns;
          tag_nxt    = in_frame_tag[TB-1:0];
          found_nxt  = 1'b0;
          etime_nxt  = '0;
          etag_nxt   = '0;
          status_nxt = tfh_pkg::ST_DONE;
          unique case (in_cmd)
            tfh_pkg::CMD_PUSH: begin
              keep_nxt = KW'(secs_r) * KW'(tfh_pkg::NS_PER_SECOND);
              if (in_time_ns == '0) begin
                state_nxt = S_FIN;
              end else begin
                status_nxt = tfh_pkg::ST_STORED;
                if (cnt_r != '0) begin
                  // fetch the newest entry
                  ring_req.rd = 1'b1;
                  ring_off    = cnt_m1[AW-1:0];
                  state_nxt   = S_NEWEST;
                end else begin
                  state_nxt = S_CUT;
                end
              end
            end
            tfh_pkg::CMD_PLAY: begin
              if (in_emitting_hold) begin
                if ((in_paused || hold_r != '0) && in_buffer_start_time != '0) begin
                  hold_nxt = in_buffer_start_time;
                  prot_nxt = in_buffer_start_time;
                end else begin
                  prot_nxt = hold_r;
                end
              end else begin
                hold_nxt = '0;
                prot_nxt = in_emitting_delayed ? in_emitted_time : '0;
              end
              susp_nxt  = in_paused;
              state_nxt = S_FIN;
            end
            tfh_pkg::CMD_LOOK: begin
              lo_nxt    = '0;
              hi_nxt    = cnt_r;
              state_nxt = S_LK_RD;
            end
            tfh_pkg::CMD_CLEAR: begin
              cnt_nxt    = '0;
              oldest_nxt = '0;
              prot_nxt   = '0;
              hold_nxt   = '0;
              susp_nxt   = 1'b0;
              state_nxt  = S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // Drop the whole history when time does not move forward
      S_NEWEST: begin
        if (cmp_le) begin
          cnt_nxt    = '0;
          oldest_nxt = '0;
          status_nxt = tfh_pkg::ST_RESET;
        end
        state_nxt = S_CUT;
      end

      // Cutoff is the new time less the window, floored at zero
      S_CUT: begin
        cutoff_nxt = cut_diff[TW] ? '0 : cut_diff[TW-1:0];
        state_nxt  = S_PROT;
      end

      // Lower the cutoff to the protected time
      S_PROT: begin
        if (prot_r != '0 && !cmp_le) begin
          cutoff_nxt = prot_r;
        end
        state_nxt = S_EV_RD;
      end

      // Fetch the second oldest entry
      S_EV_RD: begin
        if (cnt_r > CW'(1)) begin
          ring_req.rd = 1'b1;
          ring_off    = AW'(1);
          state_nxt   = S_EV_CMP;
        end else begin
          state_nxt = S_LIMIT;
        end
      end

      // Evict the oldest while the next one is still at or before the cutoff
      S_EV_CMP: begin
        if (cmp_le) begin
          oldest_nxt = oldest_inc;
          cnt_nxt    = cnt_m1;
          state_nxt  = S_EV_RD;
        end else begin
          state_nxt = S_LIMIT;
        end
      end

      // Enforce the size limit
      S_LIMIT: begin
        if (LW'(cnt_r) >= limit) begin
          if (prot_r != '0) begin
            status_nxt = tfh_pkg::ST_REFUSED;
            state_nxt  = S_FIN;
          end else begin
            oldest_nxt = oldest_inc;
            cnt_nxt    = cnt_m1;
            state_nxt  = S_WRITE;
          end
        end else begin
          state_nxt = S_WRITE;
        end
      end

      // Append the new entry
      S_WRITE: begin
        ring_req.wr = 1'b1;
        ring_off    = cnt_r[AW-1:0];
        cnt_nxt     = cnt_r + CW'(1);
        state_nxt   = S_FIN;
      end

      // Binary search: probe the middle of the open range
      S_LK_RD: begin
        if (lo_r < hi_r) begin
          ring_req.rd = 1'b1;
          ring_off    = mid_calc[AW-1:0];
          mid_nxt     = mid_calc;
          state_nxt   = S_LK_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Keep the probe when it is at or before the query time
      S_LK_CMP: begin
        if (cmp_le) begin
          found_nxt = 1'b1;
          etime_nxt = rd_time;
          etag_nxt  = rd_tag;
          lo_nxt    = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_LK_RD;
      end

      // Hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      secs_r      <= tfh_pkg::SECONDS_MIN;
      oldest_r    <= '0;
      cnt_r       <= '0;
      prot_r      <= '0;
      hold_r      <= '0;
      susp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      secs_r      <= secs_nxt;
      oldest_r    <= oldest_nxt;
      cnt_r       <= cnt_nxt;
      prot_r      <= prot_nxt;
      hold_r      <= hold_nxt;
      susp_r      <= susp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and output payload
  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    tag_r    <= tag_nxt;
    keep_r   <= keep_nxt;
    cutoff_r <= cutoff_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    found_r  <= found_nxt;
    etime_r  <= etime_nxt;
    etag_r   <= etag_nxt;
    status_r <= status_nxt;
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_found_r  <= found_r;
      out_time_r   <= etime_r;
      out_tag_r    <= etag_r;
      out_susp_r   <= susp_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_entry_time = out_time_r;
  assign out_entry_tag  = tfh_pkg::TAG_PORT_W'(out_tag_r);
  assign out_suspended  = out_susp_r;
  assign out_status     = out_status_r;

  // The history never holds more than the ring depth
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HISTORY_DEPTH))
    else $error("entry count beyond ring depth");

  // A search probe always lies inside the open range
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LK_CMP |-> (lo_r <= mid_r && mid_r < hi_r))
    else $error("search probe outside its range");

  // A clear transaction leaves the history empty
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd == tfh_pkg::CMD_CLEAR |=> cnt_r == '0 && prot_r == '0)
    else $error("history not emptied by clear");

  // An entry is only written when the ring has room for it
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |-> cnt_r < CW'(HISTORY_DEPTH))
    else $error("append into a full ring");

endmodule
